### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the table core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg)

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/kvut_pkg.sv
// ----------------------------------------------------------------------------
// kvut_pkg
// Types and constants shared by the key/value table core modules.
// ----------------------------------------------------------------------------
package kvut_pkg;

    localparam int DEFAULT_ENTRIES = 64;
    localparam int KEY_W           = 32;
    localparam int VALUE_W         = 32;
    localparam int COUNT_OUT_W     = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ
    } kvut_state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic upd_wr;
        logic new_wr;
        logic rsp_zero;
        logic rsp_full;
        logic rsp_value;
    } kvut_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_more;
        logic pend;
        logic is_write;
        logic is_full;
    } kvut_sts_t;

endpackage

### rtl/kvut_ram.sv
// ----------------------------------------------------------------------------
// kvut_ram
// Single-port RAM with one write or read address per cycle, registered read.
// ----------------------------------------------------------------------------
module kvut_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/kvut_ctrl.sv
// ----------------------------------------------------------------------------
// kvut_ctrl
// Access sequencer: scan stored keys, then read, update, insert or reject.
// ----------------------------------------------------------------------------
module kvut_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  kvut_pkg::kvut_sts_t sts,
    output kvut_pkg::kvut_cmd_t cmd,
    output logic                busy
);

    import kvut_pkg::*;

    kvut_state_t state_reg;
    kvut_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.hit)
                begin
                    state_next = sts.is_write ? ST_IDLE : ST_READ;
                end
                else if (!sts.scan_more && !sts.pend)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN:
            begin
                if (sts.hit)
                begin
                    if (sts.is_write)
                    begin
                        cmd.upd_wr   = 1'b1;
                        cmd.rsp_zero = 1'b1;
                    end
                end
                else if (sts.scan_more)
                begin
                    cmd.issue = 1'b1;
                end
                else if (!sts.pend)
                begin
                    if (sts.is_write && sts.is_full)
                    begin
                        cmd.rsp_full = 1'b1;
                    end
                    else
                    begin
                        cmd.new_wr   = sts.is_write;
                        cmd.rsp_zero = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rsp_value = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### rtl/kvut_dp.sv
// ----------------------------------------------------------------------------
// kvut_dp
// Key and value memories, access registers, scan pointer and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kvut_dp #(
    parameter int ENTRIES = kvut_pkg::DEFAULT_ENTRIES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  kvut_pkg::kvut_cmd_t                   cmd,
    output kvut_pkg::kvut_sts_t                   sts,
    input  logic                                  op,
    input  logic signed [kvut_pkg::KEY_W-1:0]     key,
    input  logic signed [kvut_pkg::VALUE_W-1:0]   value,
    output logic                                  done,
    output logic signed [kvut_pkg::VALUE_W-1:0]   read_value,
    output logic [kvut_pkg::COUNT_OUT_W-1:0]      entry_count,
    output logic                                  table_full
);

    import kvut_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic               op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic [CNT_W-1:0]   scan_idx_next;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               pend_reg;
    logic               done_reg;
    logic [VALUE_W-1:0] read_value_reg;
    logic               table_full_reg;

    logic [IDX_W-1:0]   key_addr;
    logic [IDX_W-1:0]   value_addr;
    logic [KEY_W-1:0]   key_rdata;
    logic [VALUE_W-1:0] value_rdata;

    assign key_addr   = cmd.new_wr ? count_reg[IDX_W-1:0] : scan_idx_reg[IDX_W-1:0];
    assign value_addr = cmd.new_wr ? count_reg[IDX_W-1:0] : cmp_idx_reg;

    kvut_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (cmd.new_wr),
        .addr  (key_addr),
        .wdata (key_reg),
        .rdata (key_rdata)
    );

    kvut_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .clk   (clk),
        .we    (cmd.new_wr | cmd.upd_wr),
        .addr  (value_addr),
        .wdata (value_reg),
        .rdata (value_rdata)
    );

    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        if (cmd.load)
        begin
            scan_idx_next = '0;
        end
        else if (cmd.issue)
        begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
        end
    end

    assign count_next = cmd.new_wr ? count_reg + CNT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= cmd.issue;
            done_reg     <= cmd.rsp_zero | cmd.rsp_full | cmd.rsp_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            key_reg   <= key;
            value_reg <= value;
        end
        if (cmd.issue)
        begin
            cmp_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        read_value_reg <= cmd.rsp_value ? value_rdata : '0;
        table_full_reg <= cmd.rsp_full;
    end

    always_comb
    begin
        sts           = '0;
        sts.pend      = pend_reg;
        sts.hit       = pend_reg && (key_rdata == key_reg);
        sts.scan_more = scan_idx_reg < count_reg;
        sts.is_write  = op_reg;
        sts.is_full   = count_reg == CNT_W'(ENTRIES);
    end

    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign table_full  = table_full_reg;
    assign entry_count = COUNT_OUT_W'(count_reg);

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(ENTRIES), "count above capacity")
    `ASSERT_IMPLY(a_no_insert_full, clk, rst_n, cmd.new_wr, !sts.is_full && !sts.hit, "insert into full table or on hit")
    `ASSERT_NEXT(a_count_hold, clk, rst_n, !cmd.new_wr, $stable(count_reg), "count moved without insert")
    `ASSERT_IMPLY(a_full_zero, clk, rst_n, done_reg && table_full_reg, read_value_reg == '0, "rejected beat carries data")

endmodule

### rtl/key_value_upsert_table_core.sv
// ----------------------------------------------------------------------------
// key_value_upsert_table_core
// Associative table of 32-bit keys and values with insert-or-update and lookup.
// ----------------------------------------------------------------------------
// An access is taken when start is high and busy is low. Stored keys are
// compared one per cycle out of a single-port key memory. On a key hit,
// an upsert writes the new value into that slot and a lookup reads the
// value out of the value memory. When no stored key matches, an upsert
// inserts the key and value as a new entry, or is dropped with table_full
// when the table is full. Each result is a single-cycle beat marked by done,
// and the receiver cannot stall it: capture read_value, entry_count and
// table_full on the edge that ends it. busy drops in the cycle of the beat,
// so the next access may be taken on the edge that ends it.
module key_value_upsert_table_core #(
    parameter int ENTRIES = kvut_pkg::DEFAULT_ENTRIES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic signed [kvut_pkg::KEY_W-1:0]   key,
    input  logic signed [kvut_pkg::VALUE_W-1:0] value,
    output logic                                done,
    output logic signed [kvut_pkg::VALUE_W-1:0] read_value,
    output logic [kvut_pkg::COUNT_OUT_W-1:0]    entry_count,
    output logic                                table_full
);

    import kvut_pkg::*;

    kvut_cmd_t cmd;
    kvut_sts_t sts;

    kvut_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    kvut_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .op          (op),
        .key         (key),
        .value       (value),
        .done        (done),
        .read_value  (read_value),
        .entry_count (entry_count),
        .table_full  (table_full)
    );

endmodule

### tb/kvut_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvut_tb_pkg
// Scoreboard for the key/value table core: keeps its own copy of the table,
// works out the reply of every accepted access and checks the replies in order.
// ----------------------------------------------------------------------------
package kvut_tb_pkg;

    import kvut_pkg::*;

    localparam int   TABLE_DEPTH = DEFAULT_ENTRIES;
    localparam logic OP_LOOKUP   = 1'b0;
    localparam logic OP_UPSERT   = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_OUT_W-1:0]    entry_count;
        logic                      table_full;
    } kv_reply_t;

    class kv_table_scoreboard;

        logic [KEY_W-1:0]   table_keys[TABLE_DEPTH];
        logic [VALUE_W-1:0] table_values[TABLE_DEPTH];
        int unsigned        stored_n;
        kv_reply_t          awaited_replies[$];
        int unsigned        failures;

        function new();
            stored_n = 0;
            failures = 0;
        endfunction

        function int unsigned replies_outstanding();
            return awaited_replies.size();
        endfunction

        function void record_access(logic op_w, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
            kv_reply_t reply;
            int        slot;
            reply = '0;
            slot  = -1;
            for (int i = 0; i < int'(stored_n); i++)
            begin
                if (slot < 0 && table_keys[i] == k)
                    slot = i;
            end
            if (op_w == OP_UPSERT)
            begin
                if (slot >= 0)
                    table_values[slot] = v;
                else if (stored_n < TABLE_DEPTH)
                begin
                    table_keys[stored_n]   = k;
                    table_values[stored_n] = v;
                    stored_n++;
                end
                else
                    reply.table_full = 1'b1;
            end
            else if (slot >= 0)
                reply.read_value = table_values[slot];
            reply.entry_count = COUNT_OUT_W'(stored_n);
            awaited_replies.push_back(reply);
        endfunction

        function void check_reply(logic signed [VALUE_W-1:0] rv, logic [COUNT_OUT_W-1:0] cnt,
                                  logic full);
            kv_reply_t exp_r;
            if (awaited_replies.size() == 0)
            begin
                $error("unexpected beat: read_value=%0h entry_count=%0d table_full=%0b",
                       rv, cnt, full);
                failures++;
                return;
            end
            exp_r = awaited_replies.pop_front();
            if (rv !== exp_r.read_value)
            begin
                $error("read_value: expected %0h, actual %0h", exp_r.read_value, rv);
                failures++;
            end
            if (cnt !== exp_r.entry_count)
            begin
                $error("entry_count: expected %0d, actual %0d", exp_r.entry_count, cnt);
                failures++;
            end
            if (full !== exp_r.table_full)
            begin
                $error("table_full: expected %0b, actual %0b", exp_r.table_full, full);
                failures++;
            end
        endfunction

    endclass

endpackage

### tb/tb_key_value_upsert_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_value_upsert_table_core
// Drives lookups and upserts into the table core, starting with corner keys
// and values, then random accesses that mostly reuse stored keys, fill the
// table and keep hitting it once full. Every reply beat is checked against
// the scoreboard's own copy of the table.
// ----------------------------------------------------------------------------
module tb_key_value_upsert_table_core;

    import kvut_pkg::*;
    import kvut_tb_pkg::*;

    localparam int ACCESS_COUNT = 1450;
    localparam int CALM_TAIL    = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      op;
    logic signed [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
    logic                      done;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_OUT_W-1:0]    entry_count;
    logic                      table_full;

    kv_table_scoreboard sb;
    logic [KEY_W-1:0]   key_pool[$];
    bit                 key_seen[logic [KEY_W-1:0]];
    int                 stall_cycles;
    bit                 idle_mode;

    key_value_upsert_table_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .key         (key),
        .value       (value),
        .done        (done),
        .read_value  (read_value),
        .entry_count (entry_count),
        .table_full  (table_full)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_reply(read_value, entry_count, table_full);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("** key_value_upsert_table_core: FAILED **");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic issue_access(logic op_w, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v,
                                bit allow_idle);
        start <= 1'b1;
        op    <= op_w;
        key   <= k;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.record_access(op_w, k, v);
        if (op_w == OP_UPSERT && !key_seen.exists(k))
        begin
            key_seen[k] = 1'b1;
            key_pool.push_back(k);
        end
        if (allow_idle && idle_mode && $urandom_range(0, 99) < 35)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (key_pool.size() == 0 || sel < 12)
            return $urandom;
        if (sel < 20)
            return key_pool[$urandom_range(0, key_pool.size() - 1)] ^
                   (32'h1 << $urandom_range(0, KEY_W - 1));
        if (sel < 24)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    initial
    begin
        logic             op_w;
        logic [KEY_W-1:0] k;

        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = OP_LOOKUP;
        key          = '0;
        value        = '0;
        stall_cycles = 0;
        idle_mode    = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_access(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0);
        issue_access(OP_UPSERT, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        issue_access(OP_UPSERT, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        issue_access(OP_UPSERT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        issue_access(OP_UPSERT, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        issue_access(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        issue_access(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        issue_access(OP_LOOKUP, 32'h8000_0000, 32'h5555_5555, 1'b0);
        issue_access(OP_LOOKUP, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 1'b0);
        issue_access(OP_UPSERT, 32'h0000_0000, 32'h8000_0000, 1'b0);
        issue_access(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0);
        issue_access(OP_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b0);
        issue_access(OP_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0);
        issue_access(OP_UPSERT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        issue_access(OP_UPSERT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        issue_access(OP_LOOKUP, 32'h5555_5555, 32'h0000_0000, 1'b0);
        issue_access(OP_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0);
        issue_access(OP_UPSERT, 32'hAAAA_AAAA, 32'h0000_0001, 1'b0);
        issue_access(OP_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0);

        for (int idx = 0; idx < ACCESS_COUNT; idx++)
        begin
            if (idx % 40 == 0)
                idle_mode = (idx < ACCESS_COUNT - CALM_TAIL) && ($urandom_range(0, 2) != 0);
            op_w = 1'($urandom_range(0, 1));
            k    = pick_key();
            // push the table to full in the second half if it is still short
            if (idx >= ACCESS_COUNT / 2 && sb.stored_n < TABLE_DEPTH && $urandom_range(0, 1))
            begin
                op_w = OP_UPSERT;
                k    = $urandom;
            end
            issue_access(op_w, k, $urandom, 1'b1);
        end
        start <= 1'b0;

        while (sb.replies_outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.replies_outstanding() == 0)
            $display("** key_value_upsert_table_core: PASSED **");
        else
            $display("** key_value_upsert_table_core: FAILED **");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/kvut_pkg.sv
rtl/kvut_ram.sv
rtl/kvut_ctrl.sv
rtl/kvut_dp.sv
rtl/key_value_upsert_table_core.sv
tb/kvut_tb_pkg.sv
tb/tb_key_value_upsert_table_core.sv
